>>> hw/rtl/slbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types and constants for the shared log batch sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

	localparam int unsigned BrokerCount   = 32;
	localparam int unsigned ClientEntries = 256;

	localparam int unsigned BrokerIdxW = (BrokerCount > 1) ? $clog2(BrokerCount) : 1;
	localparam int unsigned EntryIdxW  = (ClientEntries > 1) ? $clog2(ClientEntries) : 1;
	// fill count must also hold ClientEntries itself
	localparam int unsigned FillW      = $clog2(ClientEntries + 1);

	localparam int unsigned KeyW      = 40;
	localparam int unsigned SeqW      = 32;
	localparam int unsigned EntryW    = KeyW + SeqW;
	localparam int unsigned OffsetW   = 64;
	localparam int unsigned BatchCntW = 32;
	localparam int unsigned BrokerW   = OffsetW + BatchCntW;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_BAD_BROKER = 3'd1,
		STATUS_ZERO       = 3'd2,
		STATUS_DUPLICATE  = 3'd3,
		STATUS_RETRY      = 3'd4,
		STATUS_FULL       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] client_num;
		logic [7:0]  broker_num;
		logic [31:0] seq_num;
		logic [15:0] num_msg;
		logic [31:0] byte_count;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] total_order;
		logic [63:0] byte_offset;
		logic [31:0] broker_batch_num;
	} rsp_t;

endpackage

>>> hw/rtl/slbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slbs_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 2
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                        rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/shared_log_batch_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_log_batch_sequencer
// Assigns global order, broker log offset and broker batch number to batches.
// ----------------------------------------------------------------------------
// Each request word names a client, a broker, a batch sequence number, a
// message count and a byte size, and gets exactly one response word. Requests
// are handled one at a time. A request rejected for a bad broker or a zero
// count or size skips the search. Otherwise the client-broker table is
// searched linearly, one entry per cycle through the table RAM's single
// read port, stopping at the matching entry; a new pair (or a full table)
// is resolved once all n entries are read, where n is the number of pairs
// seen so far (at most ClientEntries). Entries are allocated in fill order and
// never freed. The response register lets the next request be accepted while
// a response still waits on rsp_stall. Broker counters live in a second RAM
// with per-broker valid bits, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module shared_log_batch_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  slbs_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output slbs_pkg::rsp_t    rsp
);

	slbs_pkg::state_t state_q, state_d;

	// request held for the whole sequence
	slbs_pkg::req_t   req_q;
	logic             pre_fail_q;
	slbs_pkg::status_t pre_status_q;

	// table fill count and scan pointer
	logic [slbs_pkg::FillW-1:0]     cnt_q;
	logic [slbs_pkg::FillW-1:0]     idx_q;
	logic                           chk_s1;
	logic [slbs_pkg::EntryIdxW-1:0] chk_idx_s1;

	// lookup result
	logic                           found_q;
	logic [slbs_pkg::EntryIdxW-1:0] hit_idx_q;
	logic [slbs_pkg::SeqW-1:0]      hit_exp_q;

	logic [63:0]                      glob_q;
	logic [slbs_pkg::BrokerCount-1:0] bvld_q;
	logic                             bvld_rd_q;

	logic           out_valid_q;
	slbs_pkg::rsp_t out_q;

	// RAM ports
	logic                           ent_we, ent_re;
	logic [slbs_pkg::EntryIdxW-1:0] ent_waddr, ent_raddr;
	logic [slbs_pkg::EntryW-1:0]    ent_wdata, ent_rdata;
	logic                           brk_we, brk_re;
	logic [slbs_pkg::BrokerIdxW-1:0] brk_waddr, brk_raddr;
	logic [slbs_pkg::BrokerW-1:0]   brk_wdata, brk_rdata;

	// control decode
	logic              accept, bad_broker, zero_req;
	logic              issue, match, miss;
	logic              go, full, ok, ent_write, alloc;
	logic [slbs_pkg::KeyW-1:0]   key;
	logic [slbs_pkg::SeqW-1:0]   exp_seq;
	logic [slbs_pkg::OffsetW-1:0]   boff;
	logic [slbs_pkg::BatchCntW-1:0] bcnt;
	slbs_pkg::status_t status;
	slbs_pkg::rsp_t    rsp_d;

	assign req_stall = (state_q != slbs_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign bad_broker = ({1'b0, req.broker_num} >= 9'(slbs_pkg::BrokerCount));
	assign zero_req   = (req.num_msg == '0) || (req.byte_count == '0);

	assign key = {req_q.client_num, req_q.broker_num};

	// scan: issue one read per cycle, compare the previous read's key
	assign issue = (idx_q < cnt_q);
	assign match = chk_s1 && (ent_rdata[slbs_pkg::EntryW-1:slbs_pkg::SeqW] == key);
	assign miss  = !match && !issue;

	// resolve: a miss allocates with an expected sequence of zero
	assign exp_seq = found_q ? hit_exp_q : '0;
	assign full    = !found_q && (cnt_q == slbs_pkg::FillW'(slbs_pkg::ClientEntries));
	assign boff    = bvld_rd_q ? brk_rdata[slbs_pkg::BrokerW-1:slbs_pkg::BatchCntW] : '0;
	assign bcnt    = bvld_rd_q ? brk_rdata[slbs_pkg::BatchCntW-1:0] : '0;

	always_comb begin
		priority if (pre_fail_q) begin
			status = pre_status_q;
		end else if (full) begin
			status = slbs_pkg::STATUS_FULL;
		end else if (req_q.seq_num < exp_seq) begin
			status = slbs_pkg::STATUS_DUPLICATE;
		end else if (req_q.seq_num != exp_seq) begin
			status = slbs_pkg::STATUS_RETRY;
		end else begin
			status = slbs_pkg::STATUS_OK;
		end
	end

	assign ok        = (status == slbs_pkg::STATUS_OK);
	assign alloc     = !pre_fail_q && !found_q && !full;
	assign ent_write = alloc || (found_q && ok && !pre_fail_q);

	always_comb begin
		rsp_d                  = '0;
		rsp_d.status           = status;
		if (ok) begin
			rsp_d.total_order      = glob_q;
			rsp_d.byte_offset      = boff;
			rsp_d.broker_batch_num = bcnt;
		end
	end

	// next state and RAM strobes
	always_comb begin
		state_d   = state_q;
		go        = 1'b0;
		ent_re    = 1'b0;
		ent_raddr = idx_q[slbs_pkg::EntryIdxW-1:0];
		ent_we    = 1'b0;
		ent_waddr = found_q ? hit_idx_q : cnt_q[slbs_pkg::EntryIdxW-1:0];
		ent_wdata = {key, ok ? exp_seq + 32'd1 : exp_seq};
		brk_re    = 1'b0;
		brk_raddr = req.broker_num[slbs_pkg::BrokerIdxW-1:0];
		brk_we    = 1'b0;
		brk_waddr = req_q.broker_num[slbs_pkg::BrokerIdxW-1:0];
		brk_wdata = {boff + {32'd0, req_q.byte_count}, bcnt + 32'd1};
		unique case (state_q)
			slbs_pkg::ST_IDLE: begin
				if (accept) begin
					brk_re  = 1'b1;
					state_d = (bad_broker || zero_req) ? slbs_pkg::ST_FINISH
					                                   : slbs_pkg::ST_SCAN;
				end
			end
			slbs_pkg::ST_SCAN: begin
				ent_re = issue && !match;
				if (match || miss) begin
					state_d = slbs_pkg::ST_FINISH;
				end
			end
			slbs_pkg::ST_FINISH: begin
				go = !out_valid_q || !rsp_stall;
				if (go) begin
					ent_we  = ent_write;
					brk_we  = ok;
					state_d = slbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			chk_s1      <= 1'b0;
			found_q     <= 1'b0;
			pre_fail_q  <= 1'b0;
			glob_q      <= '0;
			bvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q      <= '0;
				chk_s1     <= 1'b0;
				found_q    <= 1'b0;
				pre_fail_q <= bad_broker || zero_req;
			end
			if (state_q == slbs_pkg::ST_SCAN) begin
				chk_s1 <= ent_re;
				if (ent_re) begin
					idx_q <= idx_q + slbs_pkg::FillW'(1);
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (go) begin
				if (alloc) begin
					cnt_q <= cnt_q + slbs_pkg::FillW'(1);
				end
				if (ok) begin
					glob_q <= glob_q + {48'd0, req_q.num_msg};
					bvld_q[req_q.broker_num[slbs_pkg::BrokerIdxW-1:0]] <= 1'b1;
				end
			end
			// hold the response until taken, reload when finishing
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req;
			pre_status_q <= bad_broker ? slbs_pkg::STATUS_BAD_BROKER : slbs_pkg::STATUS_ZERO;
			bvld_rd_q    <= bvld_q[req.broker_num[slbs_pkg::BrokerIdxW-1:0]];
		end
		if (ent_re) begin
			chk_idx_s1 <= idx_q[slbs_pkg::EntryIdxW-1:0];
		end
		if (match) begin
			hit_idx_q <= chk_idx_s1;
			hit_exp_q <= ent_rdata[slbs_pkg::SeqW-1:0];
		end
		if (go) begin
			out_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// client-broker table: {key, expected sequence}
	slbs_ram #(
		.Width(slbs_pkg::EntryW),
		.Depth(slbs_pkg::ClientEntries)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	// per-broker {log offset, batch count}
	slbs_ram #(
		.Width(slbs_pkg::BrokerW),
		.Depth(slbs_pkg::BrokerCount)
	) u_broker_ram (
		.clk  (clk),
		.we   (brk_we),
		.waddr(brk_waddr),
		.wdata(brk_wdata),
		.re   (brk_re),
		.raddr(brk_raddr),
		.rdata(brk_rdata)
	);

endmodule

>>> sim/tb_shared_log_batch_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_log_batch_sequencer
// Self-checking bench for the shared log batch sequencer.
// ----------------------------------------------------------------------------
// Drive a short table of hand-picked request words, then about two thousand
// random ones. Most random words continue a known client-broker pair with the
// sequence number it is due for, so batches get ordered and the pair table
// slowly fills; the rest are new pairs, stale or early sequence numbers, bad
// brokers and zero counts or sizes. Once the table holds every pair it can,
// new pairs come back as table full. A local model of the counters and of the
// pair table predicts each response word, and the monitor compares every
// response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_shared_log_batch_sequencer;

	localparam longint LimitCycles  = 3000000;
	localparam int     RandomWords  = 1930;
	localparam int     HoldAt       = 400;  // request count that starts the long stall
	localparam int     HoldCycles   = 600;
	localparam int     PauseAt      = 1000; // request count where the sender drains
	localparam int     CalmFrom     = 1200; // no idling on either side in this window
	localparam int     CalmTo       = 1450;
	localparam int     DrainLimit   = 5000;
	localparam int     SettleCycles = 300;  // a full table scan plus margin

	typedef struct {
		slbs_pkg::req_t word;
		bit             typed;
		slbs_pkg::rsp_t want;
	} directed_row_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	slbs_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	slbs_pkg::rsp_t rsp;

	// Local copy of the sequencer state. Pairs are allocated in fill order and
	// never freed, so slot i is in use exactly when i < pairs_seen.
	logic [slbs_pkg::OffsetW-1:0]   order_count;
	logic [slbs_pkg::OffsetW-1:0]   broker_offset [slbs_pkg::BrokerCount];
	logic [slbs_pkg::BatchCntW-1:0] broker_batches [slbs_pkg::BrokerCount];
	logic [slbs_pkg::KeyW-1:0]      pair_key [slbs_pkg::ClientEntries];
	logic [slbs_pkg::SeqW-1:0]      pair_next_seq [slbs_pkg::ClientEntries];
	int                             pairs_seen;

	slbs_pkg::rsp_t pending [$];
	directed_row_t  plan [$];

	longint cycles;
	int     mismatches;
	int     requests_sent;
	int     status_hits [6];
	bit     calm;
	bit     hold_go;

	shared_log_batch_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Count cycles and stop a hung run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LimitCycles) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// Order one batch against the local state and return its response word.
	// Rejections leave every counter untouched; a new pair keeps its slot
	// even when the same request is then rejected on its sequence number.
	function automatic slbs_pkg::rsp_t order_batch(input slbs_pkg::req_t w);
		slbs_pkg::rsp_t            r;
		logic [slbs_pkg::KeyW-1:0] key;
		int                        slot;
		int                        i;
		r = '0;
		r.status = slbs_pkg::STATUS_OK;
		if (32'(w.broker_num) >= slbs_pkg::BrokerCount) begin
			r.status = slbs_pkg::STATUS_BAD_BROKER;
		end else if (w.num_msg == '0 || w.byte_count == '0) begin
			r.status = slbs_pkg::STATUS_ZERO;
		end else begin
			key = {w.client_num, w.broker_num};
			slot = -1;
			for (i = 0; i < pairs_seen; i++)
				if (pair_key[i] == key)
					slot = i;
			if (slot < 0 && pairs_seen < slbs_pkg::ClientEntries) begin
				slot = pairs_seen;
				pair_key[slot] = key;
				pair_next_seq[slot] = '0;
				pairs_seen++;
			end
			if (slot < 0) begin
				r.status = slbs_pkg::STATUS_FULL;
			end else if (w.seq_num < pair_next_seq[slot]) begin
				r.status = slbs_pkg::STATUS_DUPLICATE;
			end else if (w.seq_num != pair_next_seq[slot]) begin
				r.status = slbs_pkg::STATUS_RETRY;
			end else begin
				r.total_order = order_count;
				r.byte_offset = broker_offset[w.broker_num];
				r.broker_batch_num = broker_batches[w.broker_num];
				order_count = order_count + {48'd0, w.num_msg};
				broker_offset[w.broker_num] = broker_offset[w.broker_num]
					+ {32'd0, w.byte_count};
				broker_batches[w.broker_num] = broker_batches[w.broker_num] + 32'd1;
				pair_next_seq[slot] = pair_next_seq[slot] + 32'd1;
			end
		end
		return r;
	endfunction

	task automatic add_row(input logic [31:0] client, input logic [7:0] broker,
			input logic [31:0] seq, input logic [15:0] nmsg, input logic [31:0] size,
			input bit typed, input slbs_pkg::status_t st, input logic [63:0] ord,
			input logic [63:0] off, input logic [31:0] bnum);
		directed_row_t row;
		row.word = '{client_num: client, broker_num: broker, seq_num: seq,
			num_msg: nmsg, byte_count: size};
		row.typed = typed;
		row.want = '{status: st, total_order: ord, byte_offset: off,
			broker_batch_num: bnum};
		plan.push_back(row);
	endtask

	// Build one random request word. Most words continue a known pair so the
	// sequence checks pass and counters move; the rest probe the rejections.
	function automatic slbs_pkg::req_t random_word();
		slbs_pkg::req_t            w;
		int                        pick;
		int                        roll;
		int                        slot;
		logic [slbs_pkg::SeqW-1:0] due;
		logic [slbs_pkg::SeqW-1:0] step;
		pick = $urandom_range(99);
		w.client_num = $urandom;
		w.broker_num = 8'($urandom_range(slbs_pkg::BrokerCount - 1));
		w.seq_num = '0;
		w.num_msg = 16'($urandom_range(16'hFFFF, 1));
		w.byte_count = $urandom;
		if (w.byte_count == '0)
			w.byte_count = 32'd1;
		if ($urandom_range(15) == 0)
			w.num_msg = 16'hFFFF;
		if ($urandom_range(15) == 0)
			w.byte_count = 32'hFFFF_FFFF;
		if (pick < 5) begin
			w.broker_num = 8'($urandom_range(255, slbs_pkg::BrokerCount));
			w.seq_num = $urandom;
		end else if (pick < 10) begin
			roll = $urandom_range(2);
			if (roll != 1)
				w.num_msg = '0;
			if (roll != 0)
				w.byte_count = '0;
		end else if (pick < 30 || pairs_seen == 0) begin
			// new pair: usually opens at zero, sometimes early
			if ($urandom_range(4) == 0)
				w.seq_num = $urandom;
		end else begin
			slot = $urandom_range(pairs_seen - 1);
			{w.client_num, w.broker_num} = pair_key[slot];
			due = pair_next_seq[slot];
			roll = $urandom_range(99);
			if (roll < 75) begin
				w.seq_num = due;
			end else if (roll < 85 && due != 0) begin
				w.seq_num = $urandom_range(due - 1);
			end else begin
				step = ($urandom_range(1) == 0) ? $urandom_range(16, 1) : $urandom;
				if (step == 0)
					step = 1;
				w.seq_num = due + step;
			end
		end
		return w;
	endfunction

	// Offer one word, hold it until accepted, then record its prediction.
	task automatic send_word(input slbs_pkg::req_t w, input bit typed,
			input slbs_pkg::rsp_t want);
		slbs_pkg::rsp_t guess;
		while (!calm && $urandom_range(99) < 7) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		guess = order_batch(w);
		pending.push_back(typed ? want : guess);
		requests_sent++;
		if (requests_sent == HoldAt)
			hold_go = 1'b1;
	endtask

	task automatic check_word(input slbs_pkg::rsp_t got);
		slbs_pkg::rsp_t want;
		if (pending.size() == 0) begin
			flag_mismatch($sformatf("response with nothing pending, status %0d",
				got.status));
		end else begin
			want = pending.pop_front();
			if (got.status !== want.status)
				flag_mismatch($sformatf("status got %0d want %0d",
					got.status, want.status));
			if (got.total_order !== want.total_order)
				flag_mismatch($sformatf("total_order got %0h want %0h",
					got.total_order, want.total_order));
			if (got.byte_offset !== want.byte_offset)
				flag_mismatch($sformatf("byte_offset got %0h want %0h",
					got.byte_offset, want.byte_offset));
			if (got.broker_batch_num !== want.broker_batch_num)
				flag_mismatch($sformatf("broker_batch_num got %0h want %0h",
					got.broker_batch_num, want.broker_batch_num));
			if (got === want)
				status_hits[want.status]++;
		end
	endtask

	// Sample a response word at each edge where it is taken.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			check_word(rsp);
	end

	// Response side: random stalls, plus one long hold so the block fills up
	// and pushes back on the request side.
	initial begin : receiver
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 7);
			end
		end
	end

	initial begin : stimulus
		directed_row_t  row;
		slbs_pkg::rsp_t none;
		int             n;
		int             drain;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		none = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		mismatches = 0;
		requests_sent = 0;
		status_hits = '{default: 0};
		order_count = '0;
		pairs_seen = 0;
		for (n = 0; n < slbs_pkg::BrokerCount; n++) begin
			broker_offset[n] = '0;
			broker_batches[n] = '0;
		end

		// Directed table. Rows with typed=1 carry an answer that follows
		// directly from the ordering rules; the rest go through the local model.
		// first batch after reset gets all-zero numbers
		add_row(32'h0, 8'd0, 32'd0, 16'd1, 32'd1, 1, slbs_pkg::STATUS_OK,
			64'd0, 64'd0, 32'd0);
		// maximum count and size on the same pair
		add_row(32'h0, 8'd0, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 1, slbs_pkg::STATUS_OK,
			64'd1, 64'd1, 32'd1);
		// stale, early and far-early sequence numbers
		add_row(32'h0, 8'd0, 32'd0, 16'd1, 32'd1, 1, slbs_pkg::STATUS_DUPLICATE, 0, 0, 0);
		add_row(32'h0, 8'd0, 32'd7, 16'd1, 32'd1, 1, slbs_pkg::STATUS_RETRY, 0, 0, 0);
		add_row(32'h0, 8'd0, 32'hFFFF_FFFF, 16'd1, 32'd1, 1, slbs_pkg::STATUS_RETRY,
			0, 0, 0);
		// bad broker, also when count and size are zero: broker is checked first
		add_row(32'h0, 8'd32, 32'd0, 16'd1, 32'd1, 1, slbs_pkg::STATUS_BAD_BROKER,
			0, 0, 0);
		add_row(32'hFFFF_FFFF, 8'hFF, 32'd0, 16'd0, 32'd0, 1,
			slbs_pkg::STATUS_BAD_BROKER, 0, 0, 0);
		add_row(32'h0, 8'h80, 32'd0, 16'd1, 32'd1, 1, slbs_pkg::STATUS_BAD_BROKER,
			0, 0, 0);
		// zero count, zero size
		add_row(32'hFFFF_FFFF, 8'd31, 32'd0, 16'd0, 32'd5, 1, slbs_pkg::STATUS_ZERO,
			0, 0, 0);
		add_row(32'hFFFF_FFFF, 8'd31, 32'd0, 16'd3, 32'd0, 1, slbs_pkg::STATUS_ZERO,
			0, 0, 0);
		add_row(32'h0, 8'd0, 32'd2, 16'd0, 32'd0, 1, slbs_pkg::STATUS_ZERO, 0, 0, 0);
		// top client on the top broker
		add_row(32'hFFFF_FFFF, 8'd31, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 0,
			slbs_pkg::STATUS_OK, 0, 0, 0);
		add_row(32'hFFFF_FFFF, 8'd31, 32'd1, 16'd1, 32'd1, 0, slbs_pkg::STATUS_OK,
			0, 0, 0);
		// a new pair opening early keeps its slot, then orders from zero
		add_row(32'h5A5A_A5A5, 8'd1, 32'd3, 16'd2, 32'd9, 1, slbs_pkg::STATUS_RETRY,
			0, 0, 0);
		add_row(32'h5A5A_A5A5, 8'd1, 32'd0, 16'd2, 32'd9, 0, slbs_pkg::STATUS_OK,
			0, 0, 0);
		add_row(32'h5A5A_A5A5, 8'd1, 32'd0, 16'd2, 32'd9, 1, slbs_pkg::STATUS_DUPLICATE,
			0, 0, 0);
		// same client on another broker is a separate pair
		add_row(32'h0, 8'd1, 32'd0, 16'd4, 32'd100, 0, slbs_pkg::STATUS_OK, 0, 0, 0);
		add_row(32'h0, 8'd0, 32'd2, 16'd4, 32'd100, 0, slbs_pkg::STATUS_OK, 0, 0, 0);
		// single high bits
		add_row(32'h8000_0000, 8'd16, 32'd0, 16'h8000, 32'h8000_0000, 0,
			slbs_pkg::STATUS_OK, 0, 0, 0);
		add_row(32'h7FFF_FFFF, 8'd0, 32'd0, 16'd1, 32'd1, 0, slbs_pkg::STATUS_OK,
			0, 0, 0);

		// Sequence and counter wrap need 2^32 or more batches on one pair or
		// broker, far beyond any run length, so neither is aimed at here.

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			send_word(row.word, row.typed, row.want);
		end

		for (n = 0; n < RandomWords; n++) begin
			if (requests_sent == PauseAt) begin
				// drop valid and let every response come home
				req_valid <= 1'b0;
				while (pending.size() != 0)
					@(posedge clk);
			end
			calm = (requests_sent >= CalmFrom && requests_sent < CalmTo);
			send_word(random_word(), 1'b0, none);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		drain = 0;
		while (pending.size() != 0 && drain < DrainLimit) begin
			@(posedge clk);
			drain++;
		end
		repeat (SettleCycles) @(posedge clk);
		if (pending.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", pending.size()));

		$display("Ordered %0d requests in %0d cycles: ok %0d, bad broker %0d, zero %0d,",
			requests_sent, cycles, status_hits[slbs_pkg::STATUS_OK],
			status_hits[slbs_pkg::STATUS_BAD_BROKER], status_hits[slbs_pkg::STATUS_ZERO]);
		$display("  duplicate %0d, retry %0d, table full %0d; pair table held %0d of %0d",
			status_hits[slbs_pkg::STATUS_DUPLICATE], status_hits[slbs_pkg::STATUS_RETRY],
			status_hits[slbs_pkg::STATUS_FULL], pairs_seen, slbs_pkg::ClientEntries);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
